### src/rmv_pkg.sv
`default_nettype none

package rmv_pkg;

  localparam int DEF_COUNT_WIDTH = 32;
  localparam int DEF_FRAC_BITS   = 16;

  localparam int SAMPLE_W  = 32;   // sample and mean, signed fixed point
  localparam int CNT_OUT_W = 32;   // reported count
  localparam int VAR_W     = 48;   // reported variance
  localparam int SUM_W     = 64;   // sum of squared deviations
  localparam int OUT_W     = CNT_OUT_W + SAMPLE_W + VAR_W;

  // serial divider: dividend width and step counter width
  localparam int DIV_W      = SUM_W;
  localparam int DIV_STEP_W = $clog2(DIV_W + 1);

  typedef struct packed {
    logic busy;
    logic done;
  } rmv_div_stat_t;

endpackage

`default_nettype wire

### src/rmv_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The dividend is consumed
// from its msb; steps sets how many bits are taken.
module rmv_div
  import rmv_pkg::*;
#(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [DIV_W-1:0]       dividend,
  input  wire logic [COUNT_WIDTH-1:0] divisor,
  input  wire logic [DIV_STEP_W-1:0]  steps,
  output rmv_div_stat_t               stat,
  output logic [DIV_W-1:0]            quotient
);

  logic [DIV_W-1:0]       dvd_r, dvd_nxt;
  logic [DIV_W-1:0]       quo_r, quo_nxt;
  logic [COUNT_WIDTH-1:0] rem_r, rem_nxt;
  logic [COUNT_WIDTH-1:0] dsr_r, dsr_nxt;
  logic [DIV_STEP_W-1:0]  cnt_r, cnt_nxt;
  logic                   done_r, done_nxt;
  logic [COUNT_WIDTH:0]   trial;
  logic [COUNT_WIDTH:0]   diff;
  logic                   qbit;

  always_comb begin
    trial = {rem_r, dvd_r[DIV_W-1]};
    diff  = trial - {1'b0, dsr_r};
    qbit  = ~diff[COUNT_WIDTH];

    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt = dividend;
      quo_nxt = '0;
      rem_nxt = '0;
      dsr_nxt = divisor;
      cnt_nxt = steps;
    end else if (cnt_r != '0) begin
      dvd_nxt  = {dvd_r[DIV_W-2:0], 1'b0};
      quo_nxt  = {quo_r[DIV_W-2:0], qbit};
      // remainder stays below the divisor, so the top bit drops out
      rem_nxt  = qbit ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == DIV_STEP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat      = '{busy: (cnt_r != '0), done: done_r};
  assign quotient  = quo_r;

endmodule

`default_nettype wire

### src/running_mean_variance.sv
`default_nettype none

// Channel  Dir  Fields in tdata (lsb first)                      tuser/tlast
// in_      in   sample[31:0]                                     none
// out_     out  count[31:0] mean_value[63:32]                    none
//               variance_value[111:64]
//
// Each sample takes two passes through one serial divider (32 steps for the
// mean update, 64 for the variance) plus the sequencer states; the variance
// pass is skipped while the count is below two.
// in_tready is high only while the sequencer is idle. A finished word sits in
// the output register, so the next sample can be taken while it waits.
// rst_n clears count, mean and sum synchronously.
module running_mean_variance
  import rmv_pkg::*;
#(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [31:0]      in_tdata,   // sample[31:0]
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [OUT_W-1:0]      out_tdata   // count, mean_value, variance_value
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [VAR_W-1:0]       VAR_MAX   = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV1_GO,
    S_DIV1,
    S_DELTA2,
    S_MUL,
    S_ACC,
    S_DIV2,
    S_OUT
  } state_t;

  state_t                  state_r;
  logic [COUNT_WIDTH-1:0]  count_r;
  logic [SAMPLE_W-1:0]     mean_r;
  logic [SUM_W-1:0]        sum_r;
  logic [SAMPLE_W-1:0]     x_r;
  logic                    neg_r;
  logic [SAMPLE_W-1:0]     mag1_r, mag2_r;
  logic [SUM_W-1:0]        prod_r;
  logic [VAR_W-1:0]        var_r;
  logic                    out_tvalid_r;
  logic [OUT_W-1:0]        out_tdata_r;

  logic                    div_start;
  logic [DIV_W-1:0]        div_dividend;
  logic [COUNT_WIDTH-1:0]  div_divisor;
  logic [DIV_STEP_W-1:0]   div_steps;
  rmv_div_stat_t           div_stat;
  logic [DIV_W-1:0]        div_quo;

  logic [SAMPLE_W:0]       delta_in;
  logic [SAMPLE_W:0]       delta2;
  logic [SAMPLE_W-1:0]     quo32;
  logic [SUM_W:0]          sum_add;
  logic [SUM_W-1:0]        cnt_wide;
  logic [CNT_OUT_W-1:0]    cnt_out;
  logic                    out_free;
  logic                    in_fire;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  always_comb begin
    delta_in = {in_tdata[SAMPLE_W-1], in_tdata} - {mean_r[SAMPLE_W-1], mean_r};
    delta2   = {x_r[SAMPLE_W-1], x_r} - {mean_r[SAMPLE_W-1], mean_r};
    quo32    = div_quo[SAMPLE_W-1:0];
    sum_add  = {1'b0, sum_r} + {1'b0, prod_r};
    cnt_wide = SUM_W'(count_r);
    cnt_out  = (cnt_wide > SUM_W'({CNT_OUT_W{1'b1}})) ? '1 : cnt_wide[CNT_OUT_W-1:0];
  end

  // divider operands follow the sequencer step
  always_comb begin
    div_start    = 1'b0;
    div_dividend = {mag1_r, {(DIV_W-SAMPLE_W){1'b0}}};
    div_divisor  = count_r;
    div_steps    = DIV_STEP_W'(SAMPLE_W);
    unique case (state_r)
      S_DIV1_GO: div_start = 1'b1;
      S_ACC: begin
        div_start    = (count_r >= COUNT_WIDTH'(2));
        div_dividend = (sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0]) >> FRAC_BITS;
        div_divisor  = count_r - 1'b1;
        div_steps    = DIV_STEP_W'(DIV_W);
      end
      default: ;
    endcase
  end

  rmv_div #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      mean_r       <= '0;
      sum_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // S_OUT sets valid itself when the old word leaves
      if (out_tvalid_r && out_tready && state_r != S_OUT) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            x_r    <= in_tdata;
            neg_r  <= delta_in[SAMPLE_W];
            mag1_r <= delta_in[SAMPLE_W] ? SAMPLE_W'(-delta_in) : delta_in[SAMPLE_W-1:0];
            if (count_r != COUNT_MAX) begin
              count_r <= count_r + 1'b1;
            end
            state_r <= S_DIV1_GO;
          end
        end
        S_DIV1_GO: state_r <= S_DIV1;
        S_DIV1: begin
          if (div_stat.done) begin
            // truncated toward zero, so the new mean stays between old mean and sample
            mean_r  <= neg_r ? (mean_r - quo32) : (mean_r + quo32);
            state_r <= S_DELTA2;
          end
        end
        S_DELTA2: begin
          mag2_r  <= delta2[SAMPLE_W] ? SAMPLE_W'(-delta2) : delta2[SAMPLE_W-1:0];
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= SUM_W'(mag1_r) * SUM_W'(mag2_r);
          state_r <= S_ACC;
        end
        S_ACC: begin
          sum_r <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
          if (count_r >= COUNT_WIDTH'(2)) begin
            state_r <= S_DIV2;
          end else begin
            var_r   <= '0;
            state_r <= S_OUT;
          end
        end
        S_DIV2: begin
          if (div_stat.done) begin
            var_r   <= (div_quo[DIV_W-1:VAR_W] != '0) ? VAR_MAX : div_quo[VAR_W-1:0];
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_tdata_r  <= {var_r, mean_r, cnt_out};
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // sequencer takes one sample at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("sample taken while previous one in flight");

  // divider finishes only where the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIV1 || state_r == S_DIV2))
    else $error("divider done outside a divide step");

  // divider never restarted while running
  a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // count only moves up, by at most one
  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r) || count_r == $past(count_r) + 1'b1))
    else $error("count jumped");

  // fewer than two samples report zero variance
  a_var_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tdata_r[CNT_OUT_W-1:0] < CNT_OUT_W'(2))
      |-> (out_tdata_r[OUT_W-1:OUT_W-VAR_W] == '0))
    else $error("nonzero variance below two samples");

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rmv_pkg::*;

  localparam logic [63:0] CNT_LIMIT = (64'd1 << DEF_COUNT_WIDTH) - 64'd1;
  localparam logic [63:0] VAR_LIMIT = (64'd1 << VAR_W) - 64'd1;

  // same layout as out_tdata: count in the low bits
  typedef struct packed {
    logic [VAR_W-1:0]     variance;
    logic [SAMPLE_W-1:0]  mean;
    logic [CNT_OUT_W-1:0] count;
  } stats_t;

  class welford_board;
    stats_t      expected_stats[$];
    logic [63:0] n_taken;
    longint      avg;
    logic [63:0] sq_sum;
    int          errors;

    function new();
      n_taken = 0;
      avg     = 0;
      sq_sum  = 0;
      errors  = 0;
    endfunction

    // fold one accepted sample into the running stats and queue the result
    function void note_sample(logic [SAMPLE_W-1:0] smp);
      longint      x, d_old, d_new;
      logic [63:0] m_old, m_new, prod, vr;
      stats_t      e;
      x = longint'($signed(smp));
      if (n_taken < CNT_LIMIT) n_taken++;
      d_old = x - avg;
      avg   = avg + d_old / longint'(n_taken);   // truncates toward zero
      d_new = x - avg;
      m_old = (d_old < 0) ? -d_old : d_old;
      m_new = (d_new < 0) ? -d_new : d_new;
      prod  = m_old * m_new;
      if (sq_sum > ~64'd0 - prod) sq_sum = ~64'd0;
      else sq_sum = sq_sum + prod;
      if (n_taken < 2) begin
        vr = 0;
      end else begin
        vr = (sq_sum >> DEF_FRAC_BITS) / (n_taken - 64'd1);
        if (vr > VAR_LIMIT) vr = VAR_LIMIT;
      end
      e.count    = (n_taken > 64'hFFFF_FFFF) ? '1 : n_taken[CNT_OUT_W-1:0];
      e.mean     = avg[SAMPLE_W-1:0];
      e.variance = vr[VAR_W-1:0];
      expected_stats.insert(expected_stats.size(), e);
    endfunction

    function void flag(string fld, logic [63:0] want, logic [63:0] got);
      errors++;
      if (errors <= 10)
        $display("mismatch %s at sample %0d: expected %h, got %h",
                 fld, n_taken - expected_stats.size(), want, got);
    endfunction

    function void check_word(logic [OUT_W-1:0] word);
      stats_t got, e;
      got = word;
      if (expected_stats.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", word);
        return;
      end
      e = expected_stats.pop_front();
      if (got.count !== e.count) flag("count", e.count, got.count);
      if (got.mean !== e.mean) flag("mean_value", e.mean, got.mean);
      if (got.variance !== e.variance) flag("variance_value", e.variance, got.variance);
    endfunction
  endclass

  logic             clk;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [31:0]      in_tdata   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  welford_board tracker = new();
  bit           calm    = 1'b0;   // no idling on either side once set
  int           center  = 0;
  int           spread  = 8;
  logic [31:0]  last_smp = '0;

  running_mean_variance i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAIL running_mean_variance");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_word(out_tdata);
  end

  // result side: ready runs mixed with stall bursts
  initial begin
    int left;
    bit rdy;
    left = 0;
    rdy  = 1'b1;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        if (!calm && $urandom_range(0, 2) == 0) begin
          rdy  = 1'b0;
          left = $urandom_range(1, 18);
        end else begin
          rdy  = 1'b1;
          left = $urandom_range(1, 40);
        end
      end
      left--;
      out_tready <= rdy;
    end
  end

  task automatic put_sample(input logic [31:0] smp);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    do @(posedge clk); while (!in_tready);
    tracker.note_sample(smp);
    last_smp = smp;
  endtask

  task automatic idle_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
    end
  endtask

  // several bursts in a row so the gap can outlast the block's busy time
  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 8)) idle_sender($urandom_range(1, 18));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.expected_stats.size() != 0) @(posedge clk);
  endtask

  // mostly clustered values so the squared-deviation sum stays in range
  function automatic logic [31:0] draw_sample();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      center = int'($urandom_range(0, 2097152)) - 1048576;
      spread = $urandom_range(4, 18);
    end
    if (pick < 70)
      return center + int'($urandom_range(0, 1 << spread)) - (1 << (spread - 1));
    if (pick < 85) return int'($urandom_range(0, 31)) - 16;
    if (pick < 93) return last_smp;
    return int'($urandom) >>> $urandom_range(5, 8);
  endfunction

  initial begin
    logic [31:0] directed[$];
    directed = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                 32'hFFFF_FFFD, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0007,
                 32'hFFFF_FFF9, 32'h0000_8000, 32'hFFFF_8001, 32'h0000_0005,
                 32'h0000_0005, 32'h0000_0005, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h00FF_FF00, 32'hFF00_00FF, 32'h0000_0000, 32'h0002_0003};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      put_sample(directed[i]);
      maybe_gap();
    end
    wait_drained();

    repeat (650) begin
      put_sample(draw_sample());
      maybe_gap();
    end

    calm = 1'b1;
    repeat (30) put_sample(draw_sample());
    // full-scale swings drive the deviation sum into saturation
    repeat (6) begin
      put_sample(32'h7FFF_FFFF);
      put_sample(32'h8000_0000);
    end
    repeat (4) put_sample($urandom);
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (tracker.expected_stats.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_stats.size() == 0)
      $display("PASS running_mean_variance");
    else
      $display("FAIL running_mean_variance");
    $finish;
  end

endmodule
